// File: design/kmp_pkg.sv
// Shared constants and types for the k-transaction max profit block.
package kmp_pkg;

  localparam int KMP_MAX_TRANSACTIONS = 16;
  localparam int KMP_PRICE_BITS       = 16;

  // transactions_allowed register
  localparam int                      KMP_CFG_BITS  = 5;
  localparam logic [KMP_CFG_BITS-1:0] KMP_CFG_RESET = 5'd2;

  // control that travels down the cell chain with each price
  typedef struct packed {
    logic valid;
    logic first_day;
  } kmp_ctl_t;

endpackage

// File: design/kmp_in_if.sv
// Input channel: one price per transfer, with the series-start mark.
interface kmp_in_if #(
  parameter int PRICE_BITS = kmp_pkg::KMP_PRICE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  first_day;

  modport source (output valid, output price, output first_day, input ready);
  modport sink   (input valid, input price, input first_day, output ready);
endinterface

// File: design/kmp_out_if.sv
// Output channel: one profit result per transfer.
interface kmp_out_if #(
  parameter int PROFIT_BITS = kmp_pkg::KMP_PRICE_BITS + $clog2(kmp_pkg::KMP_MAX_TRANSACTIONS)
);
  logic                   valid;
  logic                   ready;
  logic [PROFIT_BITS-1:0] max_profit;

  modport source (output valid, output max_profit, input ready);
  modport sink   (input valid, input max_profit, output ready);
endinterface

// File: design/kmp_cell.sv
// One transaction-count cell: keeps best holding/free balances for its count.
module kmp_cell #(
  parameter int IDX         = 1,
  parameter int PRICE_BITS  = kmp_pkg::KMP_PRICE_BITS,
  parameter int PROFIT_BITS = 20,
  parameter int VAL_BITS    = 22,
  parameter int KW          = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [KW-1:0]              k_sel,
  input  kmp_pkg::kmp_ctl_t          ctl_in,
  input  logic [PRICE_BITS-1:0]      price_in,
  input  logic signed [VAL_BITS-1:0] free_in,
  input  logic [PROFIT_BITS-1:0]     res_in,
  output kmp_pkg::kmp_ctl_t          ctl_out,
  output logic [PRICE_BITS-1:0]      price_out,
  output logic signed [VAL_BITS-1:0] free_out,
  output logic [PROFIT_BITS-1:0]     res_out
);
  import kmp_pkg::*;

  localparam logic signed [VAL_BITS-1:0] UNREACH = {1'b1, {(VAL_BITS-1){1'b0}}};

  logic signed [VAL_BITS-1:0] hold;
  logic signed [VAL_BITS-1:0] free;
  logic signed [VAL_BITS-1:0] hold_cur, free_cur, p_ext;
  logic signed [VAL_BITS-1:0] buy, sell;
  logic signed [VAL_BITS-1:0] hold_next, free_next;
  logic                       hit;

  always_comb begin
    // a series start sees cleared state before this price
    hold_cur  = ctl_in.first_day ? UNREACH : hold;
    free_cur  = ctl_in.first_day ? '0 : free;
    p_ext     = signed'({{(VAL_BITS-PRICE_BITS){1'b0}}, price_in});
    buy       = free_in - p_ext;
    hold_next = (buy > hold_cur) ? buy : hold_cur;
    sell      = hold_next + p_ext;
    free_next = (sell > free_cur) ? sell : free_cur;
    hit       = (k_sel == KW'(IDX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold          <= UNREACH;
      free          <= '0;
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      ctl_out.valid     <= ctl_in.valid;
      ctl_out.first_day <= ctl_in.first_day;
      price_out         <= price_in;
      free_out          <= free_next;
      res_out           <= hit ? free_next[PROFIT_BITS-1:0] : res_in;
      if (ctl_in.valid) begin
        hold <= hold_next;
        free <= free_next;
      end
    end
  end

endmodule

// File: design/k_transaction_max_profit_top.sv
// Top level of the streaming k-transaction max profit block.
// Streaming best profit with at most k buy-then-sell transactions. Each price
// transfer updates, for every transaction count 1..MAX_TRANSACTIONS, the best
// balance while holding a share and while holding none, since the last transfer
// marked first_day (which clears those balances before its price is applied).
// The work runs down a chain of MAX_TRANSACTIONS cells, one per transaction
// count; cell j takes the price together with the new free balance of cell j-1
// from that cell's registers, so a new price can enter every cycle while the
// chain is not stalled. Each result passes through the registers of every
// cell in order and then the output register; throughput is one price per
// cycle while the output side takes results. The chain stalls as a whole
// when the output register holds a result that has not been taken.
// transactions_allowed (reset 2) selects which cell's free balance is
// reported; above MAX_TRANSACTIONS it acts as MAX_TRANSACTIONS and zero
// reports zero. Write it only while no price is in flight.
module k_transaction_max_profit_top #(
  parameter int MAX_TRANSACTIONS = kmp_pkg::KMP_MAX_TRANSACTIONS,
  parameter int PRICE_BITS       = kmp_pkg::KMP_PRICE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [kmp_pkg::KMP_CFG_BITS-1:0] cfg_wr_data,
  kmp_in_if.sink                           prices,
  kmp_out_if.source                        profits
);
  import kmp_pkg::*;

  // profit never exceeds k times the top price
  localparam int PROFIT_BITS = PRICE_BITS + $clog2(MAX_TRANSACTIONS);
  // sign bit plus headroom for the unreachable marker
  localparam int VAL_BITS    = PROFIT_BITS + 2;
  localparam int KW          = $clog2(MAX_TRANSACTIONS + 1);

  logic [KMP_CFG_BITS-1:0] transactions_allowed;
  logic [KW-1:0]           k_sel;
  logic                    advance;

  // chain links; index 0 feeds the first cell
  kmp_ctl_t                   ctl_s   [0:MAX_TRANSACTIONS];
  logic [PRICE_BITS-1:0]      price_s [0:MAX_TRANSACTIONS];
  logic signed [VAL_BITS-1:0] free_s  [0:MAX_TRANSACTIONS];
  logic [PROFIT_BITS-1:0]     res_s   [0:MAX_TRANSACTIONS];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      transactions_allowed <= KMP_CFG_RESET;
    end else if (cfg_wr_en) begin
      transactions_allowed <= cfg_wr_data;
    end
  end

  // saturate k to the chain length; k of zero matches no cell and keeps 0
  always_comb begin
    if (int'(transactions_allowed) > MAX_TRANSACTIONS) begin
      k_sel = KW'(MAX_TRANSACTIONS);
    end else begin
      k_sel = KW'(transactions_allowed);
    end
  end

  // whole chain moves when the output register is empty or being drained
  assign advance       = !profits.valid || profits.ready;
  assign prices.ready  = advance;

  assign ctl_s[0].valid     = prices.valid;
  assign ctl_s[0].first_day = prices.first_day;
  assign price_s[0]         = prices.price;
  assign free_s[0]          = '0;   // zero transactions: balance stays zero
  assign res_s[0]           = '0;

  for (genvar j = 1; j <= MAX_TRANSACTIONS; j++) begin : g_cell
    kmp_cell #(
      .IDX         (j),
      .PRICE_BITS  (PRICE_BITS),
      .PROFIT_BITS (PROFIT_BITS),
      .VAL_BITS    (VAL_BITS),
      .KW          (KW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .k_sel     (k_sel),
      .ctl_in    (ctl_s[j-1]),
      .price_in  (price_s[j-1]),
      .free_in   (free_s[j-1]),
      .res_in    (res_s[j-1]),
      .ctl_out   (ctl_s[j]),
      .price_out (price_s[j]),
      .free_out  (free_s[j]),
      .res_out   (res_s[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      profits.valid <= 1'b0;
    end else if (advance) begin
      profits.valid <= ctl_s[MAX_TRANSACTIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      profits.max_profit <= res_s[MAX_TRANSACTIONS];
    end
  end

endmodule
